// File: sv/hpd_pkg.sv
`default_nettype none

package hpd_pkg;

    // default sizes handed to the top level
    localparam int CURVE_ENTRIES_DEFAULT     = 256;
    localparam int HUE_FRACTION_BITS_DEFAULT = 4;
    localparam int QUEUE_DEPTH               = 2;

    // field widths
    localparam int HUE_W   = 13;
    localparam int SAT_W   = 10;
    localparam int VAL_W   = 10;
    localparam int DUTY_W  = 16;
    localparam int CH_W    = 8;
    localparam int LEVEL_W = 17;
    localparam int ENTRY_W = 16;
    localparam int LEVEL_Q_W = 14;

    // q2.8 unity for saturation and value
    localparam logic [SAT_W-1:0] UNIT_Q28 = 10'd256;

    // full scale after reset
    localparam logic [DUTY_W-1:0] FULL_SCALE_RESET = 16'd999;

    // floor(q / 60) = (q * RECIP_60) >> RECIP_SHIFT for q below 15360
    localparam logic [14:0] RECIP_60    = 15'd17477;
    localparam int          RECIP_SHIFT = 20;

    // e^0 .. e^7 in q20, rounded
    localparam logic [63:0] EXP_INT_Q20 [8] = '{
        64'd1048576,   64'd2850325,   64'd7747987,   64'd21061212,
        64'd57250310,  64'd155622477, 64'd423025751, 64'd1149903210
    };

    // hue sectors of sixty degrees
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    // classified color passed from front to back
    typedef struct packed {
        logic                invalid;
        sector_t             sector;
        logic [HUE_W-1:0]    frac;
        logic [LEVEL_W-1:0]  chroma;
        logic [LEVEL_W-1:0]  floor_lvl;
    } item_t;

endpackage

`default_nettype wire

// File: sv/hsv_to_pwm_duty_logistic.sv
`default_nettype none

// channel  dir  handshake            payload
// cfg      in   cfg_valid/cfg_ready  cfg_data (pwm_full_scale)
// in       in   in_valid/in_ready    hue, saturation, brightness_value
// out      out  out_valid/out_ready  red_duty, green_duty, blue_duty, input_invalid
//
// one color per cycle sustained while out_ready stays high
// path: front register, two-entry queue, five back stages ending in the output register
// reset is asynchronous: queue and pipeline empty, full scale back to 999
// an output stall freezes the back stages; the queue then fills and in_ready drops
// configuration is always ready and applies to colors that reach the last stage

module hsv_to_pwm_duty_logistic #(
    parameter int CURVE_ENTRIES     = hpd_pkg::CURVE_ENTRIES_DEFAULT,
    parameter int HUE_FRACTION_BITS = hpd_pkg::HUE_FRACTION_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output      logic                         cfg_ready,
    input  wire logic [hpd_pkg::DUTY_W-1:0]   cfg_data,
    input  wire logic                         in_valid,
    output      logic                         in_ready,
    input  wire logic [hpd_pkg::HUE_W-1:0]    hue,
    input  wire logic [hpd_pkg::SAT_W-1:0]    saturation,
    input  wire logic [hpd_pkg::VAL_W-1:0]    brightness_value,
    output      logic                         out_valid,
    input  wire logic                         out_ready,
    output      logic [hpd_pkg::DUTY_W-1:0]   red_duty,
    output      logic [hpd_pkg::DUTY_W-1:0]   green_duty,
    output      logic [hpd_pkg::DUTY_W-1:0]   blue_duty,
    output      logic                         input_invalid
);

    logic [hpd_pkg::DUTY_W-1:0] full_scale_reg;
    logic [hpd_pkg::DUTY_W-1:0] full_scale_next;
    logic                       front_valid;
    logic                       front_ready;
    hpd_pkg::item_t             front_item;
    logic                       queue_valid;
    logic                       queue_ready;
    hpd_pkg::item_t             queue_item;

    // full scale register
    assign cfg_ready       = 1'b1;
    assign full_scale_next = (cfg_valid && cfg_ready) ? cfg_data : full_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_scale_reg <= hpd_pkg::FULL_SCALE_RESET;
        else
            full_scale_reg <= full_scale_next;
    end

    // classify and split the color
    hpd_front #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .hue              (hue),
        .saturation       (saturation),
        .brightness_value (brightness_value),
        .item_valid       (front_valid),
        .item_ready       (front_ready),
        .item             (front_item)
    );

    // decoupling queue
    hpd_queue #(
        .WIDTH ( $bits(hpd_pkg::item_t)),
        .DEPTH (hpd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_item)
    );

    // rgb, eye curve and duty scaling
    hpd_back #(
        .CURVE_ENTRIES     (CURVE_ENTRIES),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .full_scale    (full_scale_reg),
        .item_valid    (queue_valid),
        .item_ready    (queue_ready),
        .item          (queue_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red_duty      (red_duty),
        .green_duty    (green_duty),
        .blue_duty     (blue_duty),
        .input_invalid (input_invalid)
    );

endmodule

`default_nettype wire

// File: sv/hpd_front.sv
`default_nettype none

module hpd_front #(
    parameter int HUE_FRACTION_BITS = hpd_pkg::HUE_FRACTION_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [hpd_pkg::HUE_W-1:0]     hue,
    input  wire logic [hpd_pkg::SAT_W-1:0]     saturation,
    input  wire logic [hpd_pkg::VAL_W-1:0]     brightness_value,
    output      logic                          item_valid,
    input  wire logic                          item_ready,
    output      hpd_pkg::item_t                item
);

    localparam logic [31:0] SEG      = 32'd60 << HUE_FRACTION_BITS;
    localparam logic [31:0] HUE_FULL = SEG * 32'd6;

    logic                        valid_reg;
    logic                        valid_next;
    hpd_pkg::item_t              item_reg;
    hpd_pkg::item_t              item_next;
    logic                        accept;
    logic                        push;
    logic [31:0]                 hue_wide;
    logic [31:0]                 hue_eff;
    logic [31:0]                 base;
    logic [2:0]                  sector_num;
    logic [17:0]                 vs_prod;
    logic [hpd_pkg::LEVEL_W-1:0] chroma;

    // front register frees when its item moves into the queue
    assign push     = valid_reg && item_ready;
    assign in_ready = !valid_reg || item_ready;
    assign accept   = in_valid && in_ready;

    // range check, sector search and chroma
    always_comb
    begin
        hue_wide   = 32'(hue);
        hue_eff    = (hue_wide == HUE_FULL) ? 32'd0 : hue_wide;
        sector_num = 3'd0;
        base       = 32'd0;
        for (int j = 1; j < 6; j++)
        begin
            if (hue_eff >= SEG * 32'(j))
            begin
                sector_num = 3'(j);
                base       = SEG * 32'(j);
            end
        end
        vs_prod = 18'(saturation[8:0]) * 18'(brightness_value[8:0]);
        chroma  = vs_prod[hpd_pkg::LEVEL_W-1:0];

        item_next.invalid   = (hue_wide > HUE_FULL) ||
                              (saturation > hpd_pkg::UNIT_Q28) ||
                              (brightness_value > hpd_pkg::UNIT_Q28);
        item_next.sector    = hpd_pkg::sector_t'(sector_num);
        item_next.frac      = hpd_pkg::HUE_W'(hue_eff - base);
        item_next.chroma    = chroma;
        item_next.floor_lvl = {brightness_value[8:0], 8'd0} - chroma;
    end

    // valid flag of the front register
    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

    // an accepted color sits in the front register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("front register lost an accepted color");

endmodule

`default_nettype wire

// File: sv/hpd_queue.sv
`default_nettype none

module hpd_queue #(
    parameter int WIDTH = $bits(hpd_pkg::item_t),
    parameter int DEPTH = hpd_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output      logic             push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             pop_valid,
    input  wire logic             pop_ready,
    output      logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // a lone push grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

// File: sv/hpd_back.sv
`default_nettype none

module hpd_back #(
    parameter int CURVE_ENTRIES     = hpd_pkg::CURVE_ENTRIES_DEFAULT,
    parameter int HUE_FRACTION_BITS = hpd_pkg::HUE_FRACTION_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [hpd_pkg::DUTY_W-1:0]   full_scale,
    input  wire logic                         item_valid,
    output      logic                         item_ready,
    input  wire hpd_pkg::item_t               item,
    output      logic                         out_valid,
    input  wire logic                         out_ready,
    output      logic [hpd_pkg::DUTY_W-1:0]   red_duty,
    output      logic [hpd_pkg::DUTY_W-1:0]   green_duty,
    output      logic [hpd_pkg::DUTY_W-1:0]   blue_duty,
    output      logic                         input_invalid
);

    localparam int SEG     = 60 << HUE_FRACTION_BITS;
    localparam int SEG_W   = $clog2(SEG + 1);
    localparam int XP_W    = $clog2(65536 * SEG + 1);
    localparam int IDX_W   = $clog2(CURVE_ENTRIES);
    localparam int IDXP_W  = hpd_pkg::CH_W + $clog2(CURVE_ENTRIES + 1);
    localparam int STAGES  = 5;
    localparam int CH_W    = hpd_pkg::CH_W;
    localparam int ENTRY_W = hpd_pkg::ENTRY_W;

    typedef logic [ENTRY_W-1:0] curve_t [CURVE_ENTRIES];

    // unsigned quotient by shift and subtract, used only while building the curve
    function automatic logic [63:0] long_quot(logic [63:0] num, logic [63:0] den);
        logic [63:0] quot;
        logic [64:0] part;
        quot = '0;
        part = '0;
        for (int b = 63; b >= 0; b--)
        begin
            part = {part[63:0], num[b]};
            if (part >= {1'b0, den})
            begin
                part    = part - {1'b0, den};
                quot[b] = 1'b1;
            end
        end
        return quot;
    endfunction

    // logistic brightness curve in q0.16, built at elaboration
    function automatic curve_t build_curve();
        curve_t      tbl;
        logic [63:0] xq;
        logic [63:0] u;
        logic [63:0] n;
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        logic [63:0] one;
        logic        neg;
        one = 64'd1 << 30;
        for (int i = 0; i < CURVE_ENTRIES; i++)
        begin
            if (i == 0)
                tbl[i] = '0;
            else
            begin
                xq = long_quot(64'(i) * 64'd65536, 64'(CURVE_ENTRIES));
                if (xq <= 64'd46080)
                begin
                    u   = 64'd39 * (64'd46080 - xq);
                    neg = 1'b0;
                end
                else
                begin
                    u   = 64'd39 * (xq - 64'd46080);
                    neg = 1'b1;
                end
                n   = u / 64'd256000;
                rem = u % 64'd256000;
                if (n > 64'd7)
                    n = 64'd7;
                r    = (rem << 30) / 64'd256000;
                term = one;
                sum  = one;
                for (int k = 1; k <= 16; k++)
                begin
                    term = long_quot((term * r) >> 30, 64'(k));
                    sum  = sum + term;
                end
                e = (sum * hpd_pkg::EXP_INT_Q20[n[2:0]]) >> 20;
                if (neg)
                    tbl[i] = ENTRY_W'(long_quot(64'd65536 * e, one + e));
                else
                    tbl[i] = ENTRY_W'(long_quot(64'd65536 << 30, one + e));
            end
        end
        return tbl;
    endfunction

    localparam curve_t CURVE = build_curve();

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic              advance;

    // stage 1 payload
    logic [XP_W-1:0]    xp_reg;
    logic [CH_W-1:0]    hi1_reg;
    logic [CH_W-1:0]    lo1_reg;
    hpd_pkg::sector_t   sec1_reg;
    logic               inv1_reg;
    // stage 2 payload
    logic [hpd_pkg::LEVEL_Q_W-1:0] q_reg;
    logic [CH_W-1:0]    hi2_reg;
    logic [CH_W-1:0]    lo2_reg;
    hpd_pkg::sector_t   sec2_reg;
    logic               inv2_reg;
    // stage 3 payload
    logic [CH_W-1:0]    chan_reg [3];
    logic               inv3_reg;
    // stage 4 payload
    logic [ENTRY_W-1:0] entry_reg [3];
    logic               inv4_reg;
    // stage 5 output register
    logic [hpd_pkg::DUTY_W-1:0] duty_reg [3];
    logic               inv5_reg;

    logic               odd_sec;
    logic [SEG_W-1:0]   ramp;
    logic [XP_W-1:0]    xp_next;
    logic [17:0]        top_lvl;
    logic [25:0]        hi_prod;
    logic [25:0]        lo_prod;
    logic [XP_W+7:0]    xp_x255;
    logic [28:0]        recip_prod;
    logic [CH_W-1:0]    mid;
    logic [CH_W-1:0]    chan_next [3];
    logic [IDXP_W-1:0]  idx_prod [3];
    logic [31:0]        duty_prod [3];

    // whole back pipeline moves unless the output holds a stalled result
    assign advance    = !vld_reg[STAGES-1] || out_ready;
    assign item_ready = advance;
    assign vld_next   = {vld_reg[STAGES-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= vld_next;
    end

    // stage 1: ramp product plus offset, and the two flat channels
    always_comb
    begin
        odd_sec = (item.sector == hpd_pkg::SEC_Y_TO_G) ||
                  (item.sector == hpd_pkg::SEC_C_TO_B) ||
                  (item.sector == hpd_pkg::SEC_M_TO_R);
        ramp    = odd_sec ? (SEG_W'(SEG) - SEG_W'(item.frac)) : SEG_W'(item.frac);
        xp_next = XP_W'(XP_W'(item.chroma) * XP_W'(ramp)) +
                  XP_W'(XP_W'(item.floor_lvl) * XP_W'(SEG));
        top_lvl = 18'(item.chroma) + 18'(item.floor_lvl);
        hi_prod = 26'(top_lvl) * 26'd255;
        lo_prod = 26'(item.floor_lvl) * 26'd255;
    end

    // stage 2: scale by 255 and drop the segment power of two and q16
    assign xp_x255 = {xp_reg, 8'd0} - (XP_W + 8)'(xp_reg);

    // stage 3: divide by sixty and route channels by sector
    always_comb
    begin
        recip_prod = 29'(q_reg) * 29'(hpd_pkg::RECIP_60);
        mid        = recip_prod[hpd_pkg::RECIP_SHIFT +: CH_W];
        case (sec2_reg)
            hpd_pkg::SEC_R_TO_Y:
            begin
                chan_next[0] = hi2_reg; chan_next[1] = mid;     chan_next[2] = lo2_reg;
            end
            hpd_pkg::SEC_Y_TO_G:
            begin
                chan_next[0] = mid;     chan_next[1] = hi2_reg; chan_next[2] = lo2_reg;
            end
            hpd_pkg::SEC_G_TO_C:
            begin
                chan_next[0] = lo2_reg; chan_next[1] = hi2_reg; chan_next[2] = mid;
            end
            hpd_pkg::SEC_C_TO_B:
            begin
                chan_next[0] = lo2_reg; chan_next[1] = mid;     chan_next[2] = hi2_reg;
            end
            hpd_pkg::SEC_B_TO_M:
            begin
                chan_next[0] = mid;     chan_next[1] = lo2_reg; chan_next[2] = hi2_reg;
            end
            default:
            begin
                chan_next[0] = hi2_reg; chan_next[1] = lo2_reg; chan_next[2] = mid;
            end
        endcase
    end

    // stage 4 index and stage 5 product, one lane per channel
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            idx_prod[k]  = IDXP_W'(chan_reg[k]) * IDXP_W'(CURVE_ENTRIES);
            duty_prod[k] = 32'(entry_reg[k]) * 32'(full_scale);
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xp_reg   <= xp_next;
            hi1_reg  <= hi_prod[16 +: CH_W];
            lo1_reg  <= lo_prod[16 +: CH_W];
            sec1_reg <= item.sector;
            inv1_reg <= item.invalid;

            q_reg    <= hpd_pkg::LEVEL_Q_W'(xp_x255 >> (HUE_FRACTION_BITS + 16));
            hi2_reg  <= hi1_reg;
            lo2_reg  <= lo1_reg;
            sec2_reg <= sec1_reg;
            inv2_reg <= inv1_reg;

            inv3_reg <= inv2_reg;
            inv4_reg <= inv3_reg;
            inv5_reg <= inv4_reg;
            for (int k = 0; k < 3; k++)
            begin
                chan_reg[k]  <= chan_next[k];
                entry_reg[k] <= CURVE[idx_prod[k][CH_W +: IDX_W]];
                duty_reg[k]  <= inv4_reg ? '0 : duty_prod[k][31:16];
            end
        end
    end

    assign out_valid     = vld_reg[STAGES-1];
    assign red_duty      = duty_reg[0];
    assign green_duty    = duty_reg[1];
    assign blue_duty     = duty_reg[2];
    assign input_invalid = inv5_reg;

    // a flagged color never drives a nonzero duty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && input_invalid) |->
            (red_duty == '0 && green_duty == '0 && blue_duty == '0))
        else $error("invalid color gave a nonzero duty");

    // the back end takes from the queue only while it can move
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !item_ready)
        else $error("back end took an item while stalled");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

module testbench;

    localparam int          CURVE_SIZE   = hpd_pkg::CURVE_ENTRIES_DEFAULT;
    localparam int          HUE_FRAC     = hpd_pkg::HUE_FRACTION_BITS_DEFAULT;
    localparam int          HUE_BITS     = hpd_pkg::HUE_W;
    localparam int          SAT_BITS     = hpd_pkg::SAT_W;
    localparam int          VAL_BITS     = hpd_pkg::VAL_W;
    localparam int          DUTY_BITS    = hpd_pkg::DUTY_W;
    localparam int unsigned SECTOR_SPAN  = 60 << HUE_FRAC;
    localparam int unsigned FULL_TURN    = 6 * SECTOR_SPAN;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned PHASE_ITEMS  = 200;

    typedef struct packed {
        logic [DUTY_BITS-1:0] red;
        logic [DUTY_BITS-1:0] green;
        logic [DUTY_BITS-1:0] blue;
        logic                 invalid;
    } duty_set_t;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [SAT_BITS-1:0] sat;
        logic [VAL_BITS-1:0] val;
    } colour_t;

    // expected duty sets in transfer order, plus the block's behavior in integer form
    class duty_scoreboard;
        duty_set_t            expected_duties [$];
        longint unsigned      eye_curve [CURVE_SIZE];
        longint unsigned      exp_whole_q20 [8];
        logic [DUTY_BITS-1:0] full_scale;
        int unsigned          mismatches;

        function new();
            exp_whole_q20 = '{64'd1048576, 64'd2850325, 64'd7747987, 64'd21061212,
                              64'd57250310, 64'd155622477, 64'd423025751, 64'd1149903210};
            for (int i = 0; i < CURVE_SIZE; i++)
                eye_curve[i] = curve_point(i);
            full_scale = hpd_pkg::FULL_SCALE_RESET;
            mismatches = 0;
        endfunction

        // logistic curve entry in q0.16, exponent built from whole part and taylor series
        function longint unsigned curve_point(int unsigned i);
            longint unsigned xq, u, n, rem, r, term, sum, e, one;
            int unsigned     k;
            bit              below;
            one = 64'd1 << 30;
            if (i == 0)
                return 0;
            xq = (64'(i) * 64'd65536) / 64'(CURVE_SIZE);
            if (xq <= 46080)
            begin
                u = 64'd39 * (64'd46080 - xq);
                below = 1'b1;
            end
            else
            begin
                u = 64'd39 * (xq - 64'd46080);
                below = 1'b0;
            end
            n = u / 64'd256000;
            rem = u % 64'd256000;
            if (n > 7)
                n = 7;
            r = (rem << 30) / 64'd256000;
            term = one;
            sum = one;
            for (k = 1; k <= 16; k++)
            begin
                term = ((term * r) >> 30) / 64'(k);
                sum += term;
            end
            e = (sum * exp_whole_q20[n]) >> 20;
            if (below)
                return (64'd65536 << 30) / (one + e);
            return (64'd65536 * e) / (one + e);
        endfunction

        // 8-bit channel level through the eye curve, scaled by the period
        function logic [DUTY_BITS-1:0] level_to_duty(longint unsigned level);
            longint unsigned idx, prod;
            idx = (level * 64'(CURVE_SIZE)) / 64'd256;
            prod = (eye_curve[idx] * 64'(full_scale)) >> 16;
            return prod[DUTY_BITS-1:0];
        endfunction

        // hsv to rgb in exact integer form, then per-channel duty
        function duty_set_t predict_duties(colour_t c);
            duty_set_t        res;
            longint unsigned  h, sec, f, chroma, floor_lvl, cf, xf, level;
            longint unsigned  comp [3];
            hpd_pkg::sector_t sec_code;
            res = '0;
            if (c.hue > FULL_TURN || c.sat > hpd_pkg::UNIT_Q28 ||
                c.val > hpd_pkg::UNIT_Q28)
            begin
                res.invalid = 1'b1;
                return res;
            end
            h = (c.hue == FULL_TURN) ? 64'd0 : 64'(c.hue);
            sec = h / 64'(SECTOR_SPAN);
            f = h % 64'(SECTOR_SPAN);
            chroma = 64'(c.val) * 64'(c.sat);
            floor_lvl = 64'(c.val) * 64'd256 - chroma;
            cf = chroma * 64'(SECTOR_SPAN);
            xf = sec[0] ? chroma * (64'(SECTOR_SPAN) - f) : chroma * f;
            sec_code = hpd_pkg::sector_t'(sec[2:0]);
            case (sec_code)
                hpd_pkg::SEC_R_TO_Y: comp = '{cf, xf, 0};
                hpd_pkg::SEC_Y_TO_G: comp = '{xf, cf, 0};
                hpd_pkg::SEC_G_TO_C: comp = '{0, cf, xf};
                hpd_pkg::SEC_C_TO_B: comp = '{0, xf, cf};
                hpd_pkg::SEC_B_TO_M: comp = '{xf, 0, cf};
                default:             comp = '{cf, 0, xf};
            endcase
            for (int j = 0; j < 3; j++)
            begin
                level = ((comp[j] + floor_lvl * 64'(SECTOR_SPAN)) * 64'd255) /
                        (64'(SECTOR_SPAN) * 64'd65536);
                if (level > 255)
                    level = 255;
                case (j)
                    0:       res.red   = level_to_duty(level);
                    1:       res.green = level_to_duty(level);
                    default: res.blue  = level_to_duty(level);
                endcase
            end
            return res;
        endfunction

        function void note_colour(colour_t c);
            expected_duties.push_back(predict_duties(c));
        endfunction

        function void check_duties(duty_set_t got);
            duty_set_t want;
            if (expected_duties.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: r=%0d g=%0d b=%0d inv=%0b",
                             got.red, got.green, got.blue, got.invalid);
                return;
            end
            want = expected_duties.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.invalid !== want.invalid)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"duty mismatch: want r=%0d g=%0d b=%0d inv=%0b, ",
                              "got r=%0d g=%0d b=%0d inv=%0b"},
                             want.red, want.green, want.blue, want.invalid,
                             got.red, got.green, got.blue, got.invalid);
            end
        endfunction

        function int unsigned pending();
            return expected_duties.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [DUTY_BITS-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [HUE_BITS-1:0]  hue;
    logic [SAT_BITS-1:0]  saturation;
    logic [VAL_BITS-1:0]  brightness_value;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DUTY_BITS-1:0] red_duty;
    logic [DUTY_BITS-1:0] green_duty;
    logic [DUTY_BITS-1:0] blue_duty;
    logic                 input_invalid;

    duty_scoreboard board;
    bit             steady_phase;
    int unsigned    ready_left   = 0;
    int unsigned    quiet_cycles = 0;

    hsv_to_pwm_duty_logistic uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .hue              (hue),
        .saturation       (saturation),
        .brightness_value (brightness_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .red_duty         (red_duty),
        .green_duty       (green_duty),
        .blue_duty        (blue_duty),
        .input_invalid    (input_invalid)
    );

    always #5 clk = ~clk;

    // idle cycles before the next color: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_phase || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random color: mostly in range with extra weight on edges, some out of range
    function automatic colour_t random_colour();
        colour_t     c;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        c.hue = HUE_BITS'($urandom_range(0, FULL_TURN));
        c.sat = SAT_BITS'($urandom_range(0, hpd_pkg::UNIT_Q28));
        c.val = VAL_BITS'($urandom_range(0, hpd_pkg::UNIT_Q28));
        if (roll < 4)
        begin
            c.hue = HUE_BITS'($urandom_range(0, 8191));
            c.sat = SAT_BITS'($urandom_range(0, 1023));
            c.val = VAL_BITS'($urandom_range(0, 1023));
        end
        else if (roll < 10)
        begin
            case ($urandom_range(0, 2))
                0:       c.hue = HUE_BITS'($urandom_range(FULL_TURN + 1, 8191));
                1:       c.sat = SAT_BITS'($urandom_range(hpd_pkg::UNIT_Q28 + 1, 1023));
                default: c.val = VAL_BITS'($urandom_range(hpd_pkg::UNIT_Q28 + 1, 1023));
            endcase
        end
        else if (roll < 25)
        begin
            c.hue = HUE_BITS'($urandom_range(0, 6) * SECTOR_SPAN);
            if ($urandom_range(0, 1) && c.hue != 0)
                c.hue = c.hue - 1'b1;
            if (c.hue > FULL_TURN)
                c.hue = HUE_BITS'(FULL_TURN);
            if ($urandom_range(0, 1))
                c.sat = $urandom_range(0, 1) ? hpd_pkg::UNIT_Q28
                                             : SAT_BITS'($urandom_range(0, 2));
            if ($urandom_range(0, 1))
                c.val = $urandom_range(0, 1) ? hpd_pkg::UNIT_Q28
                                             : VAL_BITS'($urandom_range(0, 2));
        end
        return c;
    endfunction

    // one color transfer on the input channel
    task automatic send_colour(colour_t c);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        hue              <= c.hue;
        saturation       <= c.sat;
        brightness_value <= c.val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_colour(c);
    endtask

    // hold the input idle until every pending result is back, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // period register transfer while the block is idle
    task automatic write_full_scale(logic [DUTY_BITS-1:0] period);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= period;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.full_scale = period;
    endtask

    // result check and output stall pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_duties(duty_set_t'({red_duty, green_duty, blue_duty, input_invalid}));
        if (ready_left > 0)
        begin
            ready_left = ready_left - 1;
        end
        else if (out_ready)
        begin
            out_ready <= 1'b0;
            case ($urandom_range(0, 99)) inside
                [0:79]:  ready_left = $urandom_range(0, 2);
                [80:96]: ready_left = $urandom_range(3, 11);
                default: ready_left = $urandom_range(30, 80);
            endcase
        end
        else
        begin
            out_ready <= 1'b1;
            ready_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7)
                                                    : $urandom_range(20, 150);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        colour_t              directed [21];
        logic [DUTY_BITS-1:0] periods [6];
        board        = new();
        steady_phase = 1'b0;
        rst_n            <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        hue              <= '0;
        saturation       <= '0;
        brightness_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edges of each field, every sector, full turn and out-of-range cases
        directed = '{
            '{13'd0,    10'd256,  10'd256}, '{13'd5760, 10'd256,  10'd256},
            '{13'd5761, 10'd256,  10'd256}, '{13'd8191, 10'd1023, 10'd1023},
            '{13'd480,  10'd0,    10'd256}, '{13'd480,  10'd256,  10'd0},
            '{13'd959,  10'd256,  10'd256}, '{13'd960,  10'd256,  10'd256},
            '{13'd1440, 10'd256,  10'd256}, '{13'd2400, 10'd256,  10'd256},
            '{13'd3360, 10'd256,  10'd256}, '{13'd4320, 10'd256,  10'd256},
            '{13'd5280, 10'd256,  10'd256}, '{13'd5759, 10'd256,  10'd256},
            '{13'd100,  10'd257,  10'd256}, '{13'd100,  10'd256,  10'd257},
            '{13'd100,  10'd1023, 10'd0},   '{13'd2000, 10'd128,  10'd1},
            '{13'd3000, 10'd1,    10'd256}, '{13'd4096, 10'd200,  10'd180},
            '{13'd1234, 10'd255,  10'd255}
        };
        foreach (directed[i])
            send_colour(directed[i]);

        // random phases over several periods, extremes and zero among them
        periods = '{16'hFFFF, 16'd1, 16'($urandom_range(2, 65534)), 16'd0,
                    16'($urandom_range(2, 65534)), hpd_pkg::FULL_SCALE_RESET};
        foreach (periods[p])
        begin
            write_full_scale(periods[p]);
            steady_phase = (p == 2);
            repeat (PHASE_ITEMS)
                send_colour(random_colour());
        end

        wait_drained();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/hpd_pkg.sv
sv/hpd_front.sv
sv/hpd_queue.sv
sv/hpd_back.sv
sv/hsv_to_pwm_duty_logistic.sv
bench/testbench.sv
